// ===== rtl/hkb_pkg.sv =====
// shared types and constants for the keyboard report decoder
// no dependencies
package hkb_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_BITS = 8;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam logic [7:0] MIN_REAL_KEY = 8'h03;
    localparam logic [7:0] MOD_USAGE_BASE = 8'he0;

    localparam logic [1:0] MOD_CTRL = 2'd0;
    localparam logic [1:0] MOD_SHIFT = 2'd1;
    localparam logic [1:0] MOD_ALT = 2'd2;

    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [KEY_SLOTS-1:0][7:0] key_slots_t;

    typedef struct packed {
        logic       alt;
        logic       ctrl;
        logic       shift;
        logic       released;
        logic [7:0] usage;
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODS,
        ST_RELS,
        ST_PRESS,
        ST_READ
    } state_t;

    typedef struct packed {
        logic       load_report;
        logic       mod_step;
        logic       rel_step;
        logic       press_step;
        logic       finish;
        logic       mem_rd;
        logic       out_load;
        logic [2:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } status_t;

endpackage

// ===== rtl/hkb_ctrl.sv =====
// sequencer for report diffing steps and event reads
// depends on hkb_pkg
module hkb_ctrl
    import hkb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    action,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] LAST_MOD = 3'(MOD_BITS - 1);
    localparam logic [2:0] LAST_SLOT = 3'(KEY_SLOTS - 1);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACT_REPORT)
                    begin
                        cmd.load_report = 1'b1;
                        state_next      = ST_MODS;
                        step_next       = 3'd0;
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_MODS:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == LAST_MOD)
                begin
                    state_next = ST_RELS;
                    step_next  = 3'd0;
                end
            end
            ST_RELS:
            begin
                cmd.rel_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == LAST_SLOT)
                begin
                    state_next = ST_PRESS;
                    step_next  = 3'd0;
                end
            end
            ST_PRESS:
            begin
                cmd.press_step = 1'b1;
                step_next      = step_reg + 3'd1;
                if (step_reg == LAST_SLOT)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    step_next  = 3'd0;
                end
            end
            ST_READ:
            begin
                if (!status.out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = 3'd0;
            end
        endcase
    end

    a_slot_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELS || state_reg == ST_PRESS) |-> step_reg <= LAST_SLOT)
        else $error("slot step out of range");

    a_mods_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODS && state_next == ST_RELS) |-> step_reg == LAST_MOD)
        else $error("left modifier phase early");

    a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && status.out_stall) |=> state_reg == ST_READ)
        else $error("read result dropped while output stalled");

endmodule

// ===== rtl/hkb_datapath.sv =====
// report history, held flags, event ring memory and output register
// depends on hkb_pkg
module hkb_datapath
    import hkb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic [7:0] modifier_bits,
    input  key_slots_t key_slots,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_present,
    output event_t     event_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    event_t        mem [QUEUE_DEPTH];
    event_t        rd_data_reg;
    logic          rd_empty_reg;

    logic [7:0]    prev_mod_reg;
    key_slots_t    prev_slots_reg;
    logic [7:0]    cur_mod_reg;
    key_slots_t    cur_slots_reg;
    logic          shift_reg;
    logic          ctrl_reg;
    logic          alt_reg;
    logic [AW-1:0] wr_idx_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          out_valid_reg;
    logic          present_reg;
    event_t        event_reg;

    logic          mod_up;
    logic          mod_down;
    logic [7:0]    slot_key;
    key_slots_t    search_slots;
    logic          slot_hit;
    logic          wr_en;
    event_t        wr_event;

    // one modifier bit or one slot per step
    always_comb
    begin
        mod_up       = prev_mod_reg[cmd.step] & ~cur_mod_reg[cmd.step];
        mod_down     = cur_mod_reg[cmd.step] & ~prev_mod_reg[cmd.step];
        slot_key     = cmd.rel_step ? prev_slots_reg[cmd.step] : cur_slots_reg[cmd.step];
        search_slots = cmd.rel_step ? cur_slots_reg : prev_slots_reg;
        slot_hit     = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (search_slots[j] == slot_key)
            begin
                slot_hit = 1'b1;
            end
        end
        wr_en    = 1'b0;
        wr_event = '0;
        if (cmd.mod_step)
        begin
            wr_en             = mod_up | mod_down;
            wr_event.usage    = MOD_USAGE_BASE | {5'd0, cmd.step};
            wr_event.released = mod_up;
        end
        else if (cmd.rel_step || cmd.press_step)
        begin
            wr_en             = (slot_key > MIN_REAL_KEY) && !slot_hit;
            wr_event.usage    = slot_key;
            wr_event.released = cmd.rel_step;
            wr_event.shift    = shift_reg;
            wr_event.ctrl     = ctrl_reg;
            wr_event.alt      = alt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx_reg] <= wr_event;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg  <= mem[rd_idx_reg];
            rd_empty_reg <= (rd_idx_reg == wr_idx_reg);
        end
        if (cmd.load_report)
        begin
            cur_mod_reg   <= modifier_bits;
            cur_slots_reg <= key_slots;
        end
        if (cmd.out_load)
        begin
            present_reg <= !rd_empty_reg;
            event_reg   <= rd_empty_reg ? '0 : rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mod_reg   <= '0;
            prev_slots_reg <= '0;
            shift_reg      <= 1'b0;
            ctrl_reg       <= 1'b0;
            alt_reg        <= 1'b0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mod_step && (mod_up || mod_down))
            begin
                case (cmd.step[1:0])
                    MOD_CTRL:  ctrl_reg  <= mod_down;
                    MOD_SHIFT: shift_reg <= mod_down;
                    MOD_ALT:   alt_reg   <= mod_down;
                    default:   ;
                endcase
            end
            if (wr_en)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                prev_mod_reg   <= cur_mod_reg;
                prev_slots_reg <= cur_slots_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!rd_empty_reg)
                begin
                    rd_idx_reg <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_stall = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign event_present    = present_reg;
    assign event_out        = event_reg;

    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !rd_empty_reg) |=> rd_idx_reg != $past(rd_idx_reg))
        else $error("read index did not advance on pop");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !present_reg) |-> event_reg == '0)
        else $error("empty result carries data");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_rd || cmd.out_load) |-> !wr_en)
        else $error("queue write during read");

endmodule

// ===== rtl/hid_keyboard_report_to_key_events_unit.sv =====
// keyboard report decoder: report in, raw key events out of a ring queue
// report: accepted while idle, then 20 sequencer steps (8 modifier bits,
// 6 release slots, 6 press slots) with at most one queue write each; the next request is taken back in idle
// read: memory read on accept, result loaded once the output register is free.
// reset clears history, held flags, queue indexes and output valid;
// queue memory is not cleared, an empty read yields event_present low and a zero event
module hid_keyboard_report_to_key_events_unit
    import hkb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_present,
    output logic [7:0] key_usage,
    output logic       key_released,
    output logic       shift_held,
    output logic       ctrl_held,
    output logic       alt_held
);

    cmd_t       cmd;
    status_t    status;
    key_slots_t key_slots;
    event_t     event_out;

    assign key_slots = {key_slot_5, key_slot_4, key_slot_3,
                        key_slot_2, key_slot_1, key_slot_0};

    hkb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    hkb_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .modifier_bits (modifier_bits),
        .key_slots     (key_slots),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_present (event_present),
        .event_out     (event_out)
    );

    assign key_usage    = event_out.usage;
    assign key_released = event_out.released;
    assign shift_held   = event_out.shift;
    assign ctrl_held    = event_out.ctrl;
    assign alt_held     = event_out.alt;

endmodule
